### hdl/qci_pkg.sv
// ============================================================================
// qci_pkg: shared types, breakpoint tables and conversions
// Holds the photocathode breakpoint data and the helpers that turn the raw
// (nm*100, percent*100) tables into wavelength units and Q0.16 fractions.
// ============================================================================
package qci_pkg;

  typedef enum logic [1:0] {
    MAT_BIALKALI,
    MAT_GAASP,
    MAT_GAAS
  } mat_e;

  localparam int TabCap   = 128;
  localparam int WlW      = 16;
  localparam int QeW      = 16;
  localparam int ProdW    = 32;              // delta * |dy|
  localparam int RecipW   = ProdW + 1;       // reciprocal multiplier width
  localparam int RecipLoW = 17;
  localparam int RecipHiW = RecipW - RecipLoW;
  localparam int ShiftW   = 5;

  localparam int BkN = 70;
  localparam int GpN = 62;
  localparam int GaN = 63;

  localparam int BK_XH [BkN] = '{
    25871,26425,26978,27347,27532,27716,27900,28270,28454,28639,
    28824,29193,29562,29934,30669,31223,32330,33437,34544,35836,
    40634,41373,42480,43033,43772,44510,45248,46171,46910,48016,
    48754,49493,50415,51153,51707,52261,52630,52999,53183,53737,
    54106,54660,55213,55767,56505,57243,58166,58720,59273,59827,
    60381,60750,61119,61488,61857,62226,62780,62964,63333,63702,
    64072,64625,65179,65548,65917,66286,66655,67024,67393,67762};
  localparam int BK_YH [BkN] = '{
    197,296,391,494,597,691,799,885,995,1071,
    1200,1333,1520,1659,1865,1977,2158,2288,2461,2497,
    2534,2497,2425,2390,2321,2255,2158,2035,1920,1759,
    1635,1565,1476,1392,1333,1239,1135,1040,966,860,
    776,701,614,563,501,439,374,343,300,275,
    238,215,191,170,151,131,110,99,87,75,
    65,52,39,35,30,25,21,17,13,11};

  localparam int GP_XH [GpN] = '{
    36021,36205,36390,36574,36759,36944,37128,37682,38051,38604,
    38974,39343,40081,40634,41188,41742,42664,43772,45063,45986,
    47093,48570,49862,51892,54291,55583,57059,57982,59089,60012,
    60934,61857,62595,63149,63702,64256,64810,65363,65917,66286,
    66655,67024,67578,67947,68132,68316,68685,68870,69054,69423,
    69608,69792,69977,70162,70531,70715,71084,71269,71453,71638,
    71822,72007};
  localparam int GP_YH [GpN] = '{
    39,59,137,197,296,433,588,754,939,1294,
    1659,1977,2497,2932,3248,3704,3927,4163,4413,4611,
    4748,4889,4961,4961,4818,4748,4611,4479,4350,4225,
    4044,3870,3704,3546,3394,3248,3109,2976,2807,2686,
    2571,2425,2255,2127,1977,1838,1588,1413,1294,1055,
    835,701,606,516,446,397,333,175,120,81,
    51,37};

  localparam int GA_XH [GaN] = '{
    38051,38235,38420,38604,38974,39343,39712,40081,40450,41003,
    41373,41926,42480,42664,43218,43772,44325,45433,46355,47463,
    48201,49123,50046,50784,51523,53183,55583,60011,69792,76436,
    79942,81788,82895,84002,84556,85110,85848,86401,86771,87140,
    87509,87693,88062,88247,88431,88616,88801,88985,89170,89354,
    89539,89723,89908,90092,90461,90646,90830,91015,91200,91384,
    91569,91753,91938};
  localparam int GA_YH [GaN] = '{
    93,108,139,172,234,296,353,402,494,597,
    691,799,912,995,1102,1239,1333,1498,1611,1811,
    1920,2035,2127,2222,2288,2356,2425,2497,2497,2390,
    2321,2288,2255,2158,2065,1977,1892,1733,1588,1434,
    1294,1169,1086,981,885,799,691,615,494,380,
    305,231,170,133,111,100,91,77,59,49,
    30,20,11};

  // Raw breakpoint in nm*100; entries past the data read as zero.
  function automatic int tab_xh(mat_e m, int i);
    int r;
    r = 0;
    case (m)
      MAT_BIALKALI: if (i < BkN) r = BK_XH[i];
      MAT_GAASP:    if (i < GpN) r = GP_XH[i];
      MAT_GAAS:     if (i < GaN) r = GA_XH[i];
      default:      r = 0;
    endcase
    return r;
  endfunction

  // Raw efficiency in percent*100; entries past the data read as zero.
  function automatic int tab_yh(mat_e m, int i);
    int r;
    r = 0;
    case (m)
      MAT_BIALKALI: if (i < BkN) r = BK_YH[i];
      MAT_GAASP:    if (i < GpN) r = GP_YH[i];
      MAT_GAAS:     if (i < GaN) r = GA_YH[i];
      default:      r = 0;
    endcase
    return r;
  endfunction

  // nm*100 to 1/64 nm, rounded.
  function automatic longint wl_units(int h);
    return (longint'(h) * 64 + 50) / 100;
  endfunction

  // percent*100 to Q0.16, rounded.
  function automatic longint to_q16(int h);
    return (longint'(h) * 65536 + 5000) / 10000;
  endfunction

endpackage

### hdl/qe_curve_interpolator_top.sv
// ============================================================================
// qe_curve_interpolator_top: photocathode quantum efficiency lookup
// Piecewise linear interpolation of three constant efficiency curves.
// ============================================================================
// Give one wavelength word (1/64 nm) with start and get the Bialkali, GaAsP
// and GaAs efficiencies in Q0.16 after the pipeline stages listed below, marked by a
// one-cycle valid_o pulse. A new word is taken every cycle: busy stays low,
// and results come out in the order the words went in. The five stages are
// segment search, segment constant fetch, slope product, two-half reciprocal
// multiply, and quotient/add/clamp; the reciprocal multiply sets the depth.
// Wavelengths outside a curve, and values at or below zero, return zero.
// The results cannot be held off: capture them in the cycle valid_o is high.
// ============================================================================
module qe_curve_interpolator_top #(
  parameter int BIALKALI_POINTS = 70,
  parameter int GAASP_POINTS    = 62,
  parameter int GAAS_POINTS     = 63
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [qci_pkg::WlW-1:0]   wavelength_i,
  output logic                      valid_o,
  output logic [qci_pkg::QeW-1:0]   qe_bialkali_o,
  output logic [qci_pkg::QeW-1:0]   qe_gaphos_o,
  output logic [qci_pkg::QeW-1:0]   qe_gaas_o
);
  import qci_pkg::*;

  localparam int Depth = 5;

  logic             accept;
  logic [Depth-1:0] vld_d, vld_q;

  // Never stall: every stage advances each cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits travel alongside the lane stages.
  assign vld_d = {vld_q[Depth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign valid_o = vld_q[Depth-1];

  qci_lane #(.MAT(MAT_BIALKALI), .NPTS(BIALKALI_POINTS)) u_lane_bialkali (
    .clk_i (clk_i),
    .wl_i  (wavelength_i),
    .qe_o  (qe_bialkali_o)
  );

  qci_lane #(.MAT(MAT_GAASP), .NPTS(GAASP_POINTS)) u_lane_gaasp (
    .clk_i (clk_i),
    .wl_i  (wavelength_i),
    .qe_o  (qe_gaphos_o)
  );

  qci_lane #(.MAT(MAT_GAAS), .NPTS(GAAS_POINTS)) u_lane_gaas (
    .clk_i (clk_i),
    .wl_i  (wavelength_i),
    .qe_o  (qe_gaas_o)
  );

endmodule

### hdl/qci_lane.sv
// ============================================================================
// qci_lane: five-stage interpolation datapath for one material
// Segment search, table fetch, slope product, reciprocal multiply in two
// halves, then quotient, add and clamp.
// ============================================================================
module qci_lane #(
  parameter qci_pkg::mat_e MAT  = qci_pkg::MAT_BIALKALI,
  parameter int            NPTS = 70
) (
  input  logic                     clk_i,
  input  logic [qci_pkg::WlW-1:0]  wl_i,
  output logic [qci_pkg::QeW-1:0]  qe_o
);
  import qci_pkg::*;

  localparam int NEff  = (NPTS > TabCap) ? TabCap : NPTS;
  localparam int NSeg  = NEff - 1;
  localparam int IdxW  = (NSeg > 1) ? $clog2(NSeg) : 1;
  localparam int TabD  = 2 ** IdxW;

  logic [NSeg-1:0]     match;
  logic [WlW-1:0]      x1_tab    [TabD];
  logic [QeW-1:0]      y1_tab    [TabD];
  logic [QeW-1:0]      absdy_tab [TabD];
  logic                neg_tab   [TabD];
  logic [RecipW-1:0]   m_tab     [TabD];
  logic [ShiftW-1:0]   l_tab     [TabD];

  // Per-segment constants, reciprocal m = ceil(2^(32+l)/dx), l = clog2(dx).
  for (genvar s = 0; s < TabD; s++) begin : g_seg
    if (s < NSeg) begin : g_live
      localparam longint X1  = wl_units(tab_xh(MAT, s));
      localparam longint X2  = wl_units(tab_xh(MAT, s + 1));
      localparam longint Y1  = to_q16(tab_yh(MAT, s));
      localparam longint Y2  = to_q16(tab_yh(MAT, s + 1));
      localparam bit     Ok  = (X2 > X1);
      localparam longint Dx  = Ok ? (X2 - X1) : 64'sd1;
      localparam int     L   = $clog2(Dx);
      localparam longint M   = ((64'sd1 <<< (32 + L)) + Dx - 1) / Dx;
      localparam longint Dy  = Y2 - Y1;
      assign match[s]     = Ok && ({16'b0, wl_i} >= X1[31:0]) && ({16'b0, wl_i} < X2[31:0]);
      assign x1_tab[s]    = X1[WlW-1:0];
      assign y1_tab[s]    = Y1[QeW-1:0];
      assign absdy_tab[s] = (Dy < 0) ? QeW'(-Dy) : QeW'(Dy);
      assign neg_tab[s]   = (Dy < 0);
      assign m_tab[s]     = M[RecipW-1:0];
      assign l_tab[s]     = ShiftW'(L);
    end else begin : g_pad
      assign x1_tab[s]    = '0;
      assign y1_tab[s]    = '0;
      assign absdy_tab[s] = '0;
      assign neg_tab[s]   = 1'b0;
      assign m_tab[s]     = '0;
      assign l_tab[s]     = '0;
    end
  end

  // Stage 1: first matching segment.
  logic [IdxW-1:0] idx_d, idx_q;
  logic            hit_d, hit1_q;
  logic [WlW-1:0]  wl1_q;

  always_comb begin
    idx_d = '0;
    hit_d = 1'b0;
    for (int s = NSeg - 1; s >= 0; s--) begin
      if (match[s]) begin
        idx_d = IdxW'(s);
        hit_d = 1'b1;
      end
    end
  end

  // Stage 2: fetch segment constants.
  logic [WlW-1:0]    delta2_q;
  logic [QeW-1:0]    absdy2_q, y1_2_q;
  logic              neg2_q, hit2_q;
  logic [RecipW-1:0] m2_q;
  logic [ShiftW-1:0] l2_q;

  // Stage 3: slope product.
  logic [ProdW-1:0]  prod3_q;
  logic [QeW-1:0]    y1_3_q;
  logic              neg3_q, hit3_q;
  logic [RecipW-1:0] m3_q;
  logic [ShiftW-1:0] l3_q;

  // Stage 4: reciprocal partial products.
  logic [ProdW+RecipLoW-1:0] plo4_q;
  logic [ProdW+RecipHiW-1:0] phi4_q;
  logic [QeW-1:0]            y1_4_q;
  logic                      neg4_q, hit4_q;
  logic [ShiftW-1:0]         l4_q;

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    hit1_q   <= hit_d;
    wl1_q    <= wl_i;

    delta2_q <= wl1_q - x1_tab[idx_q];
    absdy2_q <= absdy_tab[idx_q];
    y1_2_q   <= y1_tab[idx_q];
    neg2_q   <= neg_tab[idx_q];
    m2_q     <= m_tab[idx_q];
    l2_q     <= l_tab[idx_q];
    hit2_q   <= hit1_q;

    prod3_q  <= ProdW'(delta2_q) * ProdW'(absdy2_q);
    y1_3_q   <= y1_2_q;
    neg3_q   <= neg2_q;
    m3_q     <= m2_q;
    l3_q     <= l2_q;
    hit3_q   <= hit2_q;

    plo4_q   <= (ProdW+RecipLoW)'(prod3_q) * (ProdW+RecipLoW)'(m3_q[RecipLoW-1:0]);
    phi4_q   <= (ProdW+RecipHiW)'(prod3_q) * (ProdW+RecipHiW)'(m3_q[RecipW-1:RecipLoW]);
    y1_4_q   <= y1_3_q;
    neg4_q   <= neg3_q;
    l4_q     <= l3_q;
    hit4_q   <= hit3_q;
  end

  // Stage 5: quotient, signed add, clamp.
  localparam int FullW = ProdW + RecipW;
  logic [FullW-1:0] full;
  logic [FullW-1:0] quo_full;
  logic [QeW-1:0]   quo;
  logic [QeW+1:0]   res;
  logic [QeW-1:0]   qe_d, qe_q;

  always_comb begin
    full     = {phi4_q, {RecipLoW{1'b0}}} + FullW'(plo4_q);
    quo_full = full >> (7'd32 + 7'(l4_q));
    quo      = quo_full[QeW-1:0];
    res      = neg4_q ? ((QeW+2)'(y1_4_q) - (QeW+2)'(quo))
                      : ((QeW+2)'(y1_4_q) + (QeW+2)'(quo));
    if (!hit4_q || res[QeW+1] || (res == '0)) begin
      qe_d = '0;
    end else if (res[QeW]) begin
      qe_d = '1;
    end else begin
      qe_d = res[QeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    qe_q <= qe_d;
  end

  assign qe_o = qe_q;

endmodule

### hdl/qci_checker.sv
// ============================================================================
// qci_checker: port-level checks for the efficiency interpolator
// Latency, one result per word, and zero output below the first breakpoint.
// ============================================================================
module qci_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic [qci_pkg::WlW-1:0]  wavelength_i,
  input logic                     valid_o,
  input logic [qci_pkg::QeW-1:0]  qe_bialkali_o,
  input logic [qci_pkg::QeW-1:0]  qe_gaphos_o,
  input logic [qci_pkg::QeW-1:0]  qe_gaas_o
);
  import qci_pkg::*;

  localparam longint BkFirst = wl_units(tab_xh(MAT_BIALKALI, 0));
  localparam longint GpFirst = wl_units(tab_xh(MAT_GAASP, 0));
  localparam longint GaFirst = wl_units(tab_xh(MAT_GAAS, 0));

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 valid_o)
    else $error("accepted word produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##5 !valid_o)
    else $error("result without accepted word");

  a_bk_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ({16'b0, wavelength_i} < BkFirst[31:0])) |-> ##5
    (qe_bialkali_o == '0))
    else $error("bialkali nonzero below curve");

  a_gp_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ({16'b0, wavelength_i} < GpFirst[31:0])) |-> ##5
    (qe_gaphos_o == '0))
    else $error("gaasp nonzero below curve");

  a_ga_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ({16'b0, wavelength_i} < GaFirst[31:0])) |-> ##5
    (qe_gaas_o == '0))
    else $error("gaas nonzero below curve");

endmodule

bind qe_curve_interpolator_top qci_checker u_qci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .wavelength_i  (wavelength_i),
  .valid_o       (valid_o),
  .qe_bialkali_o (qe_bialkali_o),
  .qe_gaphos_o   (qe_gaphos_o),
  .qe_gaas_o     (qe_gaas_o)
);

### dv/qe_curve_interpolator_top_test.sv
// ----------------------------------------------------------------------------
// qe_curve_interpolator_top_test: efficiency lookup regression
// Drives wavelength words through the start/busy handshake, predicts the three
// photocathode efficiencies with a local piecewise linear model and checks
// every strobed result in order, under several sender idling patterns.
// ----------------------------------------------------------------------------
module qe_curve_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qci_pkg::*;

  typedef struct {
    logic [QeW-1:0] bialkali;
    logic [QeW-1:0] gaasp;
    logic [QeW-1:0] gaas;
  } qe_word_t;

  // Point counts of the block's breakpoint tables, which hold raw units (nm*100, percent*100).
  localparam int NPT_BK = 70;
  localparam int NPT_GP = 62;
  localparam int NPT_GA = 63;

  // Interpolate one curve at one wavelength; zero off the curve.
  function automatic logic [QeW-1:0] curve_qe(mat_e m, int npts, logic [WlW-1:0] wl);
    longint w, x1, x2, y1, y2, q;
    int n;
    n = (npts > TabCap) ? TabCap : npts;
    w = longint'(wl);
    for (int i = 0; i + 1 < n; i++) begin
      x1 = (longint'(tab_xh(m, i)) * 64 + 50) / 100;
      x2 = (longint'(tab_xh(m, i + 1)) * 64 + 50) / 100;
      if (w >= x1 && w < x2) begin
        y1 = (longint'(tab_yh(m, i)) * 65536 + 5000) / 10000;
        y2 = (longint'(tab_yh(m, i + 1)) * 65536 + 5000) / 10000;
        q = y1 + ((w - x1) * (y2 - y1)) / (x2 - x1);
        if (q <= 0) return '0;
        if (q > 65535) q = 65535;
        return q[QeW-1:0];
      end
    end
    return '0;
  endfunction

  class qe_scoreboard;
    qe_word_t pending[$];
    int errors;

    function void note_wavelength(logic [WlW-1:0] wl);
      qe_word_t e;
      e.bialkali = curve_qe(MAT_BIALKALI, NPT_BK, wl);
      e.gaasp    = curve_qe(MAT_GAASP, NPT_GP, wl);
      e.gaas     = curve_qe(MAT_GAAS, NPT_GA, wl);
      pending.push_back(e);
    endfunction

    function void check_result(qe_word_t got);
      qe_word_t e;
      if (pending.size() == 0) begin
        $error("result with no wavelength pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.bialkali !== e.bialkali) begin
        $error("qe_bialkali expected %0d actual %0d", e.bialkali, got.bialkali);
        errors++;
      end
      if (got.gaasp !== e.gaasp) begin
        $error("qe_gaphos expected %0d actual %0d", e.gaasp, got.gaasp);
        errors++;
      end
      if (got.gaas !== e.gaas) begin
        $error("qe_gaas expected %0d actual %0d", e.gaas, got.gaas);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [WlW-1:0] wavelength_i = '0;
  logic valid_o;
  logic [QeW-1:0] qe_bialkali_o, qe_gaphos_o, qe_gaas_o;

  qe_scoreboard sb = new();
  int idle_pct;
  int idle_pct_list[4] = '{0, 72, 10, 0};

  qe_curve_interpolator_top dut (
    .clk_i, .rst_ni, .start, .busy, .wavelength_i,
    .valid_o, .qe_bialkali_o, .qe_gaphos_o, .qe_gaas_o
  );

  always #5 clk_i = ~clk_i;

  // Capture every strobed result; the receiver never stalls.
  always @(posedge clk_i) begin
    qe_word_t got;
    if (rst_ni && valid_o) begin
      got.bialkali = qe_bialkali_o;
      got.gaasp    = qe_gaphos_o;
      got.gaas     = qe_gaas_o;
      sb.check_result(got);
    end
  end

  // Offer one word and hold start until it is taken; idle first at random.
  task automatic send_wavelength(logic [WlW-1:0] wl);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    wavelength_i <= wl;
    do @(posedge clk_i); while (busy);
    sb.note_wavelength(wl);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Wavelength in 1/64 nm of a raw breakpoint.
  function automatic logic [WlW-1:0] bp_wl(mat_e m, int i);
    return WlW'((longint'(tab_xh(m, i)) * 64 + 50) / 100);
  endfunction

  // Mostly on the curves, at, just below and just above breakpoints; some anywhere.
  function automatic logic [WlW-1:0] rand_wavelength();
    int k;
    k = $urandom_range(9);
    if (k < 5) return WlW'($urandom_range(16000, 59000));
    if (k < 8) begin
      return WlW'(bp_wl(mat_e'($urandom_range(2)), $urandom_range(62))
                  + $urandom_range(2) - 1);
    end
    return WlW'($urandom);
  endfunction

  initial begin
    logic [WlW-1:0] directed[$];
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, each curve's ends and neighbors, and a clamp-prone tail.
    directed = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                 WlW'(bp_wl(MAT_BIALKALI, 0) - 1), bp_wl(MAT_BIALKALI, 0),
                 WlW'(bp_wl(MAT_BIALKALI, 69) - 1), bp_wl(MAT_BIALKALI, 69),
                 WlW'(bp_wl(MAT_GAASP, 0) - 1), bp_wl(MAT_GAASP, 0),
                 WlW'(bp_wl(MAT_GAASP, 61) - 1), bp_wl(MAT_GAASP, 61),
                 WlW'(bp_wl(MAT_GAAS, 0) - 1), bp_wl(MAT_GAAS, 0),
                 WlW'(bp_wl(MAT_GAAS, 62) - 1), bp_wl(MAT_GAAS, 62),
                 bp_wl(MAT_BIALKALI, 20), WlW'(bp_wl(MAT_GAASP, 22) + 5),
                 WlW'(bp_wl(MAT_GAAS, 28) - 1), 16'd30000};
    foreach (directed[i]) send_wavelength(directed[i]);
    // Pause the sender until every expected word has come back.
    drain();

    foreach (idle_pct_list[p]) begin
      idle_pct = idle_pct_list[p];
      repeat (100) send_wavelength(rand_wavelength());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
